/* rtl/sp256i_pkg.sv */
// Shared types, constants and byte-level functions for the inverse permutation.
// No dependencies.
package sp256i_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t x0;
        word_t y0;
        word_t x1;
        word_t y1;
        word_t x2;
        word_t y2;
        word_t x3;
        word_t y3;
    } state_t;

    localparam int SpnRounds = 15;

    localparam logic [7:0] GfPoly = 8'h1b;

    localparam word_t RCON [8] = '{
        32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
        32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
    };

    localparam word_t SPN_KEY [16] = '{
        32'h46b9dd2b, 32'h0ba88d13, 32'h233b3feb, 32'h743eeb24,
        32'h3fcd52ea, 32'h62b81b82, 32'hb50c2764, 32'h6ed5762f,
        32'hd75dc4dd, 32'hd8c0f200, 32'hcb05019d, 32'h67b592f6,
        32'hfc821c49, 32'h479ab486, 32'h40292eac, 32'hb3b7c4be
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
    endfunction

    function automatic word_t inv_mix(input word_t w);
        logic [7:0] b0, b1, b2, b3, e8, q02, q13;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        e8  = gf_dbl(gf_dbl(gf_dbl(b0 ^ b1 ^ b2 ^ b3)));
        q02 = gf_dbl(gf_dbl(b0 ^ b2));
        q13 = gf_dbl(gf_dbl(b1 ^ b3));
        return {e8 ^ q13 ^ gf_dbl(b0 ^ b3) ^ b0 ^ b1 ^ b2,
                e8 ^ q02 ^ gf_dbl(b2 ^ b3) ^ b0 ^ b1 ^ b3,
                e8 ^ q13 ^ gf_dbl(b1 ^ b2) ^ b0 ^ b2 ^ b3,
                e8 ^ q02 ^ gf_dbl(b0 ^ b1) ^ b1 ^ b2 ^ b3};
    endfunction

    function automatic word_t inv_sub(input word_t w);
        return {INV_SBOX[w[31:24]], INV_SBOX[w[23:16]], INV_SBOX[w[15:8]], INV_SBOX[w[7:0]]};
    endfunction

    function automatic word_t ell(input word_t v);
        word_t t;
        t = v ^ {v[15:0], 16'h0000};
        return {t[15:0], t[31:16]};
    endfunction

endpackage

/* rtl/sp256i_if.sv */
// Valid/ready channel carrying one 256-bit permutation state.
// Depends on sp256i_pkg.
interface sp256i_if
    import sp256i_pkg::*;
();
    logic   valid;
    logic   ready;
    state_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/sp256i_step.sv */
// One inverse step as a pipeline of SpnRounds+2 register stages:
// linear layer, one SPN round per stage, then key 0 and step constants.
// Depends on sp256i_pkg.
module sp256i_step
    import sp256i_pkg::*;
#(
    parameter int STEP_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [STEP_W-1:0] step_idx,
    input  logic              in_valid,
    input  state_t            in_data,
    output logic              out_valid,
    output state_t            out_data
);

    localparam int NStage = SpnRounds + 2;

    logic   valid_reg [NStage];
    word_t  word_reg  [NStage][8];

    word_t  lin_next  [8];
    word_t  t_x, t_y;
    word_t  o_x0, o_x1, o_x2, o_x3, o_y0, o_y1, o_y2, o_y3;

    always_comb
    begin
        o_x0 = in_data.x2; o_x1 = in_data.x3; o_x2 = in_data.x1; o_x3 = in_data.x0;
        o_y0 = in_data.y2; o_y1 = in_data.y3; o_y2 = in_data.y1; o_y3 = in_data.y0;
        t_x = ell(o_y0 ^ o_y1);
        o_x2 = o_x2 ^ t_x ^ o_x0;
        o_x3 = o_x3 ^ t_x ^ o_x1;
        t_y = ell(o_x0 ^ o_x1);
        o_y2 = o_y2 ^ t_y ^ o_y0;
        o_y3 = o_y3 ^ t_y ^ o_y1;
        lin_next[0] = o_x0; lin_next[1] = o_y0; lin_next[2] = o_x1; lin_next[3] = o_y1;
        lin_next[4] = o_x2; lin_next[5] = o_y2; lin_next[6] = o_x3; lin_next[7] = o_y3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NStage; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NStage; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // stage r (1..15) applies key 16-r, mix, sub; last stage adds key 0 and constants
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < 8; j++)
            begin
                word_reg[0][j] <= lin_next[j];
            end
            for (int r = 1; r <= SpnRounds; r++)
            begin
                for (int j = 0; j < 8; j++)
                begin
                    word_reg[r][j] <= inv_sub(inv_mix(word_reg[r-1][j] ^ SPN_KEY[16-r]));
                end
            end
            for (int j = 0; j < 8; j++)
            begin
                word_reg[NStage-1][j] <= word_reg[NStage-2][j] ^ SPN_KEY[0]
                    ^ ((j == 3) ? word_t'(step_idx) : '0)
                    ^ ((j == 1) ? RCON[step_idx[2:0]] : '0);
            end
        end
    end

    assign out_valid = valid_reg[NStage-1];
    assign out_data  = '{x0: word_reg[NStage-1][0], y0: word_reg[NStage-1][1],
                         x1: word_reg[NStage-1][2], y1: word_reg[NStage-1][3],
                         x2: word_reg[NStage-1][4], y2: word_reg[NStage-1][5],
                         x3: word_reg[NStage-1][6], y3: word_reg[NStage-1][7]};

endmodule

/* rtl/sparkle256_inverse_spn_permutation.sv */
// Accepts one request per cycle unless a held result is not taken.
// Each inverse step is 17 stages (linear layer, 15 SPN rounds, final key/constants),
// one table lookup plus InvMixColumns per round stage; the whole pipe stalls together
// when the result is not taken, so nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// Depends on sp256i_pkg, sp256i_if, sp256i_step.
module sparkle256_inverse_spn_permutation
    import sp256i_pkg::*;
#(
    parameter int STEPS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    sp256i_if.sink      in_ch,
    sp256i_if.source    out_ch
);

    // at least 3 bits so the round constant index always exists
    localparam int StepW = (STEPS > 8) ? $clog2(STEPS) : 3;

    logic   advance;
    logic   v_chain [STEPS+1];
    state_t d_chain [STEPS+1];

    // stalls only when a result is held and not taken
    assign advance     = out_ch.ready || !v_chain[STEPS];
    assign in_ch.ready = advance;

    assign v_chain[0] = in_ch.valid;
    assign d_chain[0] = in_ch.data;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        sp256i_step #(.STEP_W(StepW)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step_idx  (StepW'(STEPS - 1 - g)),
            .in_valid  (v_chain[g]),
            .in_data   (d_chain[g]),
            .out_valid (v_chain[g+1]),
            .out_data  (d_chain[g+1])
        );
    end

    assign out_ch.valid = v_chain[STEPS];
    assign out_ch.data  = d_chain[STEPS];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken during stall");

endmodule

/* verif/tb_top.sv */
// Testbench for the inverse SPARKLE-256 SPN permutation: random and directed states,
// checked against a behavioral predictor. Needs sp256i_pkg, sp256i_if and the DUT.
module tb_top;
    import sp256i_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTEPS = 14;
    localparam int LATENCY = NSTEPS * 17;
    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    sp256i_if in_ch();
    sp256i_if out_ch();

    sparkle256_inverse_spn_permutation #(.STEPS(NSTEPS)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

    state_t pending_q[$];
    state_t expected_q[$];
    int     errors = 0;
    int     phase = 0;
    int     cycles = 0;

    function automatic logic [7:0] dbl8(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t unmix_word(input word_t w);
        logic [7:0] b[4];
        logic [7:0] e8, q02, q13;
        logic [7:0] r[4];
        for (int i = 0; i < 4; i++) b[i] = w[8*i +: 8];
        e8  = dbl8(dbl8(dbl8(b[0] ^ b[1] ^ b[2] ^ b[3])));
        q02 = dbl8(dbl8(b[0] ^ b[2]));
        q13 = dbl8(dbl8(b[1] ^ b[3]));
        r[0] = e8 ^ q02 ^ dbl8(b[0] ^ b[1]) ^ b[1] ^ b[2] ^ b[3];
        r[1] = e8 ^ q13 ^ dbl8(b[1] ^ b[2]) ^ b[0] ^ b[2] ^ b[3];
        r[2] = e8 ^ q02 ^ dbl8(b[2] ^ b[3]) ^ b[0] ^ b[1] ^ b[3];
        r[3] = e8 ^ q13 ^ dbl8(b[0] ^ b[3]) ^ b[0] ^ b[1] ^ b[2];
        return {r[3], r[2], r[1], r[0]};
    endfunction

    function automatic word_t spn_inverse(input word_t w);
        word_t v;
        v = w;
        for (int k = 15; k > 0; k--)
        begin
            v = unmix_word(v ^ SPN_KEY[k]);
            for (int j = 0; j < 4; j++) v[8*j +: 8] = INV_SBOX[v[8*j +: 8]];
        end
        return v ^ SPN_KEY[0];
    endfunction

    function automatic word_t mix_ell(input word_t v);
        word_t t;
        t = v ^ (v << 16);
        return {t[15:0], t[31:16]};
    endfunction

    function automatic state_t unpermute(input state_t s);
        word_t x[4], y[4], xo[4], yo[4], t;
        state_t r;
        x = '{s.x0, s.x1, s.x2, s.x3};
        y = '{s.y0, s.y1, s.y2, s.y3};
        for (int st = NSTEPS - 1; st >= 0; st--)
        begin
            xo = x;
            yo = y;
            x = '{xo[2], xo[3], xo[1], xo[0]};
            y = '{yo[2], yo[3], yo[1], yo[0]};
            t = mix_ell(y[0] ^ y[1]);
            x[2] ^= t ^ x[0];
            x[3] ^= t ^ x[1];
            t = mix_ell(x[0] ^ x[1]);
            y[2] ^= t ^ y[0];
            y[3] ^= t ^ y[1];
            for (int j = 0; j < 4; j++)
            begin
                x[j] = spn_inverse(x[j]);
                y[j] = spn_inverse(y[j]);
            end
            y[1] ^= word_t'(st);
            y[0] ^= RCON[st % 8];
        end
        r = '{x0: x[0], y0: y[0], x1: x[1], y1: y[1], x2: x[2], y2: y[2], x3: x[3], y3: y[3]};
        return r;
    endfunction

    function automatic bit idle_roll(input bit is_send);
        int pct;
        case (phase)
            0: pct = is_send ? 11 : 53;
            1: pct = is_send ? 53 : 11;
            default: pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_q.push_back(unpermute(in_ch.data));
                void'(pending_q.pop_front());
            end
            if (pending_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                !(in_ch.valid && !in_ch.ready))
            begin
                if (pending_q.size() > 0 && !idle_roll(1'b1))
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_q[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
            else if (pending_q.size() == 0)
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result %h", $realtime, out_ch.data);
                end
                else if (out_ch.data !== expected_q[0])
                begin
                    errors++;
                    $display("%0t mismatch expected %h actual %h",
                             $realtime, expected_q[0], out_ch.data);
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
            out_ch.ready <= !idle_roll(1'b0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic state_t rand_state();
        state_t s;
        for (int i = 0; i < 8; i++) s[32*i +: 32] = $urandom();
        return s;
    endfunction

    initial
    begin
        state_t s;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: all zeros, all ones, walking words, alternating and single-bit patterns
        pending_q.push_back('0);
        pending_q.push_back('1);
        for (int i = 0; i < 8; i++)
        begin
            s = '0;
            s[32*i +: 32] = 32'hFFFFFFFF;
            pending_q.push_back(s);
        end
        pending_q.push_back({8{32'hAAAAAAAA}});
        pending_q.push_back({8{32'h55555555}});
        pending_q.push_back({8{32'h00000001}});
        pending_q.push_back({8{32'h80000000}});
        for (int p = 0; p < 3; p++)
        begin
            while (pending_q.size() > 0) @(posedge clk);
            phase = p;
            for (int n = 0; n < 183; n++) pending_q.push_back(rand_state());
        end
        while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);
        while (expected_q.size() > 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
